/* sv/pss_pkg.sv */
// Shared types, constants and helpers for the packet size statistics block.
package pss_pkg;

  // Field widths
  localparam int LEN_W       = 16;
  localparam int ADDR_W      = 32;
  localparam int BYTES_W     = 40;
  localparam int COUNT_W     = 32;
  localparam int CMD_W       = 2;
  localparam int BIN_SEL_W   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Default histogram depth
  localparam int HIST_DEPTH_DEF = 16;

  // Divider: quotient bits resolved per clock
  localparam int DIV_STEPS = 4;

  // Register reset values
  localparam logic [LEN_W-1:0]  BIN_WIDTH_RST   = 16'd100;
  localparam logic [ADDR_W-1:0] FILTER_ADDR_RST = 32'h7F00_0001;  // loopback
  localparam logic              FILTER_EN_RST   = 1'b1;

  // Saturation limits
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BIN_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ADDR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_EN   = 2'd2;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PACKET = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } pss_cmd_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_WB,
    ST_FIN,
    ST_CLEAR
  } pss_state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } pss_div_stat_t;

  // Saturating increment of a counter
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

/* sv/pss_if.sv */
// Item channel interfaces: packet command input and statistics result output.
interface pss_in_if;
  logic                           valid;
  logic                           ready;
  logic [pss_pkg::CMD_W-1:0]      command;
  logic [pss_pkg::ADDR_W-1:0]     src_address;
  logic [pss_pkg::ADDR_W-1:0]     dst_address;
  logic [pss_pkg::LEN_W-1:0]      packet_length;
  logic [pss_pkg::BIN_SEL_W-1:0]  bin_select;

  modport source (output valid, command, src_address, dst_address, packet_length,
                  bin_select, input ready);
  modport sink   (input valid, command, src_address, dst_address, packet_length,
                  bin_select, output ready);
endinterface

interface pss_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [pss_pkg::BYTES_W-1:0]   total_bytes;
  logic [pss_pkg::COUNT_W-1:0]   packet_count;
  logic [pss_pkg::LEN_W-1:0]     min_length;
  logic [pss_pkg::LEN_W-1:0]     max_length;
  logic [pss_pkg::COUNT_W-1:0]   bin_count;

  modport source (output valid, accepted, total_bytes, packet_count, min_length,
                  max_length, bin_count, input ready);
  modport sink   (input valid, accepted, total_bytes, packet_count, min_length,
                  max_length, bin_count, output ready);
endinterface

/* sv/packet_size_statistics_core.sv */
// Packet length statistics with a length histogram; top level and control sequencer.
//
// One command item at a time. A counted packet goes through the divider (4 quotient
// bits a clock) that finds the bin, then the bin is read from the histogram RAM and
// written back incremented. A filtered packet, an unused command or a bin read skips
// the divider. A clear sweeps the histogram RAM one bin a cycle; the same sweep runs
// after reset, and no item is taken during it (configuration writes are taken
// throughout). A finished result sits in an output register, so the next item is
// taken while it waits.
module packet_size_statistics_core #(
  parameter int HIST_DEPTH = pss_pkg::HIST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pss_in_if.sink                            in_if,
  pss_out_if.source                         out_if,
  input  logic                              cfg_wr_en,
  input  logic [pss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pss_pkg::*;

  localparam int IDX_W     = $clog2(HIST_DEPTH);
  localparam int SEL_PAD_W = IDX_W + BIN_SEL_W;

  // Configuration registers
  logic [LEN_W-1:0]   bin_width_r;
  logic [ADDR_W-1:0]  filter_addr_r;
  logic               filter_en_r;

  // Control
  pss_state_t         state_r, state_nxt;
  pss_cmd_t           cmd_r;
  pss_cmd_t           in_cmd;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   sweep_r, sweep_nxt;
  logic               sweep_on, sweep_last;

  // Running totals
  logic [BYTES_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0]   min_r, min_nxt;
  logic [LEN_W-1:0]   max_r, max_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_acc_r;
  logic [BYTES_W-1:0] out_total_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [LEN_W-1:0]   out_min_r;
  logic [LEN_W-1:0]   out_max_r;
  logic [COUNT_W-1:0] out_bin_r;

  // Datapath signals
  logic               in_fire, drop, sel_ok, slot_free, produce;
  logic [SEL_PAD_W-1:0] sel_pad;
  logic [IDX_W-1:0]   sel_idx, q_idx;
  logic [LEN_W-1:0]   quotient;
  pss_div_stat_t      div_stat;
  logic               div_start;
  logic               mem_wr_en, mem_rd_en;
  logic [IDX_W-1:0]   mem_wr_addr, mem_rd_addr;
  logic [COUNT_W-1:0] mem_wr_data, mem_rd_data, bin_inc;
  logic [BYTES_W:0]   sum_wide;

  // Decode the incoming item
  assign in_cmd    = pss_cmd_t'(in_if.command);
  assign in_fire   = in_if.valid && in_if.ready;
  assign drop      = filter_en_r && ((in_if.src_address == filter_addr_r) ||
                                     (in_if.dst_address == filter_addr_r));
  assign sel_ok    = {{(LEN_W - BIN_SEL_W){1'b0}}, in_if.bin_select} < LEN_W'(HIST_DEPTH);
  assign sel_pad   = SEL_PAD_W'(in_if.bin_select);
  assign sel_idx   = sel_pad[IDX_W-1:0];
  assign q_idx     = (quotient >= LEN_W'(HIST_DEPTH)) ? IDX_W'(HIST_DEPTH - 1)
                                                      : quotient[IDX_W-1:0];
  assign slot_free = !out_valid_r || out_if.ready;
  assign sweep_on  = (state_r == ST_INIT) || (state_r == ST_CLEAR);
  assign sweep_last = (sweep_r == IDX_W'(HIST_DEPTH - 1));
  assign bin_inc   = sat_inc(mem_rd_data);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r   <= BIN_WIDTH_RST;
      filter_addr_r <= FILTER_ADDR_RST;
      filter_en_r   <= FILTER_EN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BIN_WIDTH:   bin_width_r   <= cfg_data[LEN_W-1:0];
        CFG_FILTER_ADDR: filter_addr_r <= cfg_data[ADDR_W-1:0];
        CFG_FILTER_EN:   filter_en_r   <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:  if (sweep_last) state_nxt = ST_IDLE;
      ST_CLEAR: if (sweep_last) state_nxt = ST_FIN;
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_PACKET: state_nxt = drop ? ST_FIN : ST_DIV;
            CMD_READ:   state_nxt = sel_ok ? ST_WB : ST_FIN;
            CMD_CLEAR:  state_nxt = ST_CLEAR;
            CMD_NONE:   state_nxt = ST_FIN;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_DIV:   if (div_stat.done) state_nxt = ST_WB;
      ST_WB:    if (slot_free) state_nxt = ST_IDLE;
      ST_FIN:   if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider start, RAM ports
  always_comb begin
    in_if.ready = (state_r == ST_IDLE);
    div_start   = in_fire && (in_cmd == CMD_PACKET) && !drop;
    mem_rd_en   = (in_fire && (in_cmd == CMD_READ) && sel_ok) ||
                  ((state_r == ST_DIV) && div_stat.done);
    mem_rd_addr = (state_r == ST_DIV) ? q_idx : sel_idx;
    mem_wr_en   = sweep_on ||
                  ((state_r == ST_WB) && slot_free && (cmd_r == CMD_PACKET));
    mem_wr_addr = sweep_on ? sweep_r : idx_r;
    mem_wr_data = sweep_on ? '0 : bin_inc;
    produce     = ((state_r == ST_WB) || (state_r == ST_FIN)) && slot_free;
    sweep_nxt   = sweep_on ? (sweep_last ? '0 : sweep_r + IDX_W'(1)) : sweep_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  // Hold the command and the bin being updated
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
    end
    if ((state_r == ST_DIV) && div_stat.done) begin
      idx_r <= q_idx;
    end
  end

  // Update the running totals on acceptance
  always_comb begin
    total_nxt = total_r;
    count_nxt = count_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_wide  = {1'b0, total_r} + (BYTES_W + 1)'(in_if.packet_length);
    if (in_fire && (in_cmd == CMD_PACKET) && !drop) begin
      total_nxt = sum_wide[BYTES_W] ? BYTES_MAX : sum_wide[BYTES_W-1:0];
      count_nxt = sat_inc(count_r);
      if (in_if.packet_length < min_r) min_nxt = in_if.packet_length;
      if (in_if.packet_length > max_r) max_nxt = in_if.packet_length;
    end else if (in_fire && (in_cmd == CMD_CLEAR)) begin
      total_nxt = '0;
      count_nxt = '0;
      min_nxt   = LEN_MAX;
      max_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      count_r <= '0;
      min_r   <= LEN_MAX;
      max_r   <= '0;
    end else begin
      total_r <= total_nxt;
      count_r <= count_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_acc_r   <= (state_r == ST_WB) && (cmd_r == CMD_PACKET);
      out_total_r <= total_r;
      out_count_r <= count_r;
      out_min_r   <= min_r;
      out_max_r   <= max_r;
      if (state_r == ST_WB) begin
        out_bin_r <= (cmd_r == CMD_PACKET) ? bin_inc : mem_rd_data;
      end else begin
        out_bin_r <= '0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.accepted     = out_acc_r;
  assign out_if.total_bytes  = out_total_r;
  assign out_if.packet_count = out_count_r;
  assign out_if.min_length   = out_min_r;
  assign out_if.max_length   = out_max_r;
  assign out_if.bin_count    = out_bin_r;

  // Bin quotient unit
  pss_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_if.packet_length),
    .divisor  (bin_width_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Histogram store
  pss_hist_ram #(
    .HIST_DEPTH (HIST_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

`ifndef SYNTH
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (min_r <= max_r))
    else $error("minimum length above maximum with packets counted");
  a_empty_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> ((total_r == '0) && (max_r == '0) && (min_r == LEN_MAX)))
    else $error("empty capture with non-empty totals");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_WB || $past(state_r) == ST_FIN))
    else $error("result raised outside a finishing state");
`endif

endmodule

/* sv/pss_divider.sv */
// Iterative restoring divider giving the histogram bin quotient of length / width.
module pss_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pss_pkg::LEN_W-1:0]  dividend,
  input  logic [pss_pkg::LEN_W-1:0]  divisor,
  output logic [pss_pkg::LEN_W-1:0]  quotient,
  output pss_pkg::pss_div_stat_t     stat
);
  import pss_pkg::*;

  localparam int ITERS = LEN_W / DIV_STEPS;
  localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W:0]     rem_r, rem_nxt;
  logic [LEN_W-1:0]   qd_r, qd_nxt;
  logic [LEN_W-1:0]   dvs_r;

  // Resolve DIV_STEPS quotient bits from the running remainder
  always_comb begin
    logic [LEN_W:0]   rem_t;
    logic [LEN_W-1:0] qd_t;
    rem_t = rem_r;
    qd_t  = qd_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_t = {rem_t[LEN_W-1:0], qd_t[LEN_W-1]};
      qd_t  = {qd_t[LEN_W-2:0], 1'b0};
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_t    = rem_t - {1'b0, dvs_r};
        qd_t[0]  = 1'b1;
      end
    end
    rem_nxt = rem_t;
    qd_nxt  = qd_t;
  end

  // Iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      qd_r  <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qd_r  <= qd_nxt;
    end
  end

  assign quotient  = qd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_no_double_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider busy and done together");
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");
`endif

endmodule

/* sv/pss_hist_ram.sv */
// Histogram bin store: one write port and one registered read port.
module pss_hist_ram #(
  parameter int HIST_DEPTH = pss_pkg::HIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(HIST_DEPTH)-1:0] wr_addr,
  input  logic [pss_pkg::COUNT_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(HIST_DEPTH)-1:0] rd_addr,
  output logic [pss_pkg::COUNT_W-1:0]   rd_data
);
  import pss_pkg::*;

  logic [COUNT_W-1:0] mem [HIST_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* tb/pss_stats_checker.sv */
// Checker for the packet size statistics core: predicts every result and compares it.
`timescale 1ns / 1ps

module pss_stats_checker #(
  parameter int HIST_DEPTH = pss_pkg::HIST_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pss_in_if                               in_ch,
  pss_out_if                              out_ch,
  input  logic                            cfg_wr_en,
  input  logic [pss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              waiting,
  output int                              failures
);
  import pss_pkg::*;

  typedef struct packed {
    logic               accepted;
    logic [BYTES_W-1:0] total_bytes;
    logic [COUNT_W-1:0] packet_count;
    logic [LEN_W-1:0]   min_length;
    logic [LEN_W-1:0]   max_length;
    logic [COUNT_W-1:0] bin_count;
  } stats_t;

  stats_t due_q[$];

  // Shadow of the statistics store and the registers
  logic [COUNT_W-1:0] hist [HIST_DEPTH];
  logic [BYTES_W-1:0] byte_sum;
  logic [COUNT_W-1:0] pkt_cnt;
  logic [LEN_W-1:0]   len_lo;
  logic [LEN_W-1:0]   len_hi;
  logic [LEN_W-1:0]   width_cfg;
  logic [ADDR_W-1:0]  addr_cfg;
  logic               en_cfg;

  initial begin
    failures = 0;
    waiting  = 0;
  end

  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
    return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
  endfunction

  task automatic clear_totals();
    for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
    byte_sum = '0;
    pkt_cnt  = '0;
    len_lo   = {LEN_W{1'b1}};
    len_hi   = '0;
  endtask

  // Work out the result of the item just taken and queue it
  task automatic predict_item();
    stats_t           r;
    int unsigned      slot;
    logic [BYTES_W:0] sum;
    logic [LEN_W-1:0] len;
    r   = '0;
    len = in_ch.packet_length;
    case (pss_cmd_t'(in_ch.command))
      CMD_PACKET: begin
        if (!(en_cfg && (in_ch.src_address == addr_cfg ||
                         in_ch.dst_address == addr_cfg))) begin
          sum      = {1'b0, byte_sum} + (BYTES_W + 1)'(len);
          byte_sum = sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
          pkt_cnt  = count_up(pkt_cnt);
          if (len < len_lo) len_lo = len;
          if (len > len_hi) len_hi = len;
          // Zero width sends everything to the last bin
          if (width_cfg == '0) begin
            slot = HIST_DEPTH - 1;
          end else begin
            slot = 32'(len) / 32'(width_cfg);
            if (slot >= HIST_DEPTH) slot = HIST_DEPTH - 1;
          end
          hist[slot]  = count_up(hist[slot]);
          r.bin_count = hist[slot];
          r.accepted  = 1'b1;
        end
      end
      CMD_READ: begin
        if (int'(in_ch.bin_select) < HIST_DEPTH) r.bin_count = hist[int'(in_ch.bin_select)];
      end
      CMD_CLEAR: clear_totals();
      default: ;
    endcase
    r.total_bytes  = byte_sum;
    r.packet_count = pkt_cnt;
    r.min_length   = len_lo;
    r.max_length   = len_hi;
    due_q = {due_q, r};
  endtask

  task automatic field_check(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Compare the result item with the oldest prediction
  task automatic check_result();
    stats_t e;
    if (due_q.size() == 0) begin
      $error("result item with no prediction waiting");
      failures++;
    end else begin
      e = due_q.pop_front();
      field_check("accepted", 64'(e.accepted), 64'(out_ch.accepted));
      field_check("total_bytes", 64'(e.total_bytes), 64'(out_ch.total_bytes));
      field_check("packet_count", 64'(e.packet_count), 64'(out_ch.packet_count));
      field_check("min_length", 64'(e.min_length), 64'(out_ch.min_length));
      field_check("max_length", 64'(e.max_length), 64'(out_ch.max_length));
      field_check("bin_count", 64'(e.bin_count), 64'(out_ch.bin_count));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_cfg = 16'd100;
      addr_cfg  = 32'h7F00_0001;
      en_cfg    = 1'b1;
      clear_totals();
      due_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BIN_WIDTH:   width_cfg = cfg_data[LEN_W-1:0];
          CFG_FILTER_ADDR: addr_cfg  = cfg_data[ADDR_W-1:0];
          CFG_FILTER_EN:   en_cfg    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_item();
    end
    waiting = due_q.size();
  end

endmodule

/* tb/tb_packet_size_statistics_core.sv */
// Testbench top for the packet size statistics core: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_packet_size_statistics_core;
  import pss_pkg::*;

  localparam int HIST_DEPTH   = HIST_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 130;
  localparam logic [ADDR_W-1:0] LOOPBACK = 32'h7F00_0001;

  logic                   clk   = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int failures;
  int waiting;
  int cycles     = 0;
  int ready_hold = 0;
  bit calm       = 1'b0;

  // Current register values, used to aim the stimulus
  logic [LEN_W-1:0]  cur_width  = 16'd100;
  logic [ADDR_W-1:0] cur_filter = LOOPBACK;

  pss_in_if  in_ch ();
  pss_out_if out_ch ();

  packet_size_statistics_core #(.HIST_DEPTH(HIST_DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pss_stats_checker #(.HIST_DEPTH(HIST_DEPTH)) stats_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .waiting   (waiting),
    .failures  (failures)
  );

  always #4 clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_packet_size_statistics_core NOT OK");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result side at random
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold   <= pick_gap();
    end
  end

  // Offer one item, hold it until taken, then idle for a random gap, possibly none
  task automatic send(input pss_cmd_t cmd, input logic [ADDR_W-1:0] src,
                      input logic [ADDR_W-1:0] dst, input logic [LEN_W-1:0] len,
                      input logic [BIN_SEL_W-1:0] sel);
    int n;
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.src_address   <= src;
    in_ch.dst_address   <= dst;
    in_ch.packet_length <= len;
    in_ch.bin_select    <= sel;
    do @(posedge clk); while (!in_ch.ready);
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(input logic [LEN_W-1:0] w, input logic [ADDR_W-1:0] a,
                           input logic e);
    write_reg(CFG_BIN_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FILTER_ADDR, a);
    write_reg(CFG_FILTER_EN, CFG_DATA_W'(e));
    cur_width  = w;
    cur_filter = a;
  endtask

  // Address that hits the filter now and then
  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return cur_filter;
    if (r < 12) return LOOPBACK;
    return $urandom;
  endfunction

  // One random item, mostly packet events with lengths spread over the bins
  task automatic rand_item();
    int               c;
    int               r;
    int               span;
    logic [LEN_W-1:0] len;
    pss_cmd_t         cmd;
    c = $urandom_range(0, 99);
    if (c < 74) cmd = CMD_PACKET;
    else if (c < 88) cmd = CMD_READ;
    else if (c < 93) cmd = CMD_CLEAR;
    else cmd = CMD_NONE;
    span = (cur_width == '0) ? 65535 : int'(cur_width) * HIST_DEPTH;
    if (span > 65535) span = 65535;
    r = $urandom_range(0, 99);
    if (r < 60) len = LEN_W'($urandom_range(0, span));
    else if (r < 72) len = LEN_W'($urandom_range(0, 20));
    else len = LEN_W'($urandom);
    send(cmd, pick_addr(), pick_addr(), len, BIN_SEL_W'($urandom));
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_NONE;
    in_ch.src_address   <= '0;
    in_ch.dst_address   <= '0;
    in_ch.packet_length <= '0;
    in_ch.bin_select    <= '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Defaults: width 100, loopback filtered
    send(CMD_READ, '0, '0, '0, 4'd0);
    send(CMD_PACKET, 32'h0A00_0001, 32'h0A00_0002, 16'd0, 4'd0);
    send(CMD_PACKET, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 4'hF);
    send(CMD_PACKET, 32'h0A00_0003, 32'h0A00_0004, 16'd99, 4'd0);
    send(CMD_PACKET, 32'h0A00_0005, 32'h0A00_0006, 16'd100, 4'd0);
    send(CMD_PACKET, 32'h0A00_0007, 32'h0A00_0008, 16'd1600, 4'd0);
    send(CMD_PACKET, LOOPBACK, 32'h0A00_0009, 16'd200, 4'd0);
    send(CMD_PACKET, 32'h0A00_000A, LOOPBACK, 16'd300, 4'd0);
    send(CMD_READ, '0, '0, '0, 4'd15);
    send(CMD_READ, '0, '0, '0, 4'd1);
    send(CMD_NONE, $urandom, $urandom, LEN_W'($urandom), BIN_SEL_W'($urandom));
    send(CMD_CLEAR, '0, '0, '0, 4'd0);
    send(CMD_READ, '0, '0, '0, 4'd15);
    send(CMD_PACKET, 32'h0A00_000B, 32'h0A00_000C, 16'd42, 4'd0);
    drain();

    // Zero bin width, filter off
    configure(16'd0, LOOPBACK, 1'b0);
    send(CMD_PACKET, LOOPBACK, LOOPBACK, 16'd5, 4'd0);
    send(CMD_READ, '0, '0, '0, 4'd15);
    drain();

    // Unit bin width, filter on address zero
    configure(16'd1, 32'h0000_0000, 1'b1);
    send(CMD_PACKET, 32'h0000_0000, 32'h0A00_000D, 16'd7, 4'd0);
    send(CMD_PACKET, 32'h0A00_000E, 32'h0A00_000F, 16'd3, 4'd0);
    send(CMD_PACKET, 32'h0A00_0010, 32'h0A00_0011, 16'd15, 4'd0);
    drain();

    // Widest bins, filter on all ones
    configure(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send(CMD_PACKET, 32'h0A00_0012, 32'hFFFF_FFFF, 16'd9, 4'd0);
    send(CMD_PACKET, 32'h0A00_0013, 32'h0A00_0014, 16'hFFFF, 4'd0);
    send(CMD_PACKET, 32'h0A00_0015, 32'h0A00_0016, 16'hFFFE, 4'd0);
    send(CMD_READ, '0, '0, '0, 4'd1);
    send(CMD_CLEAR, '0, '0, '0, 4'd0);
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(16'd1, LOOPBACK, 1'b1);
        1: configure(16'hFFFF, $urandom, 1'b0);
        2: configure(16'd0, LOOPBACK, 1'b1);
        3: configure(LEN_W'($urandom), $urandom, 1'b1);
        default: configure(LEN_W'($urandom_range(1, 300)), pick_addr(),
                           1'($urandom_range(0, 1)));
      endcase
      calm = (p == 2 || p == 5);
      repeat (PHASE_ITEMS) rand_item();
      drain();
    end
    calm = 1'b0;

    if (failures == 0) begin
      $display("tb_packet_size_statistics_core OK");
    end else begin
      $display("tb_packet_size_statistics_core NOT OK");
    end
    $finish;
  end

endmodule
